[sv/ccache_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccache_pkg
// Shared constants, operation codes and interface types of the CLOCK
// replacement cache.
// ----------------------------------------------------------------------------
package ccache_pkg;

  localparam int SLOTS    = 16;
  localparam int KEY_BITS = 32;
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int AGE_W    = 16;

  // operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_FETCH  = 2'd1;
  localparam logic [1:0] FUNC_EXISTS = 2'd2;
  localparam logic [1:0] FUNC_TICK   = 2'd3;

  // configuration register indexes
  localparam logic REG_SLOTS = 1'b0;
  localparam logic REG_AGE   = 1'b1;

  localparam logic [CNT_W-1:0] SLOTS_RESET = CNT_W'(SLOTS);
  localparam logic [AGE_W-1:0] AGE_RESET   = AGE_W'(500);

  // key store access from the sequencer
  typedef struct packed {
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [KEY_BITS-1:0] wdata;
    logic [IDX_W-1:0]    raddr;
  } mem_req_t;

  // one result word
  typedef struct packed {
    logic                hit;
    logic [KEY_BITS-1:0] value;
    logic [IDX_W-1:0]    slot_index;
    logic [CNT_W-1:0]    occupancy;
  } res_t;

endpackage

[sv/ccache_key_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccache_key_store
// Key memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ccache_key_store (
  input  logic                        clk,
  input  ccache_pkg::mem_req_t        req,
  output logic [ccache_pkg::KEY_BITS-1:0] rd_key
);
  import ccache_pkg::*;

  logic [KEY_BITS-1:0] mem [SLOTS];
  logic [KEY_BITS-1:0] rd_key_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_key_r <= mem[req.raddr];
  end

  assign rd_key = rd_key_r;

endmodule

[sv/ccache_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccache_seq
// Sequencer: scans the active slots one per cycle through a single key
// comparator, then fills, updates or runs the CLOCK hand sweep.
// ----------------------------------------------------------------------------
module ccache_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [1:0]                      func,
  input  logic [ccache_pkg::KEY_BITS-1:0] key,
  input  logic [ccache_pkg::CNT_W-1:0]    n_act,
  input  logic [ccache_pkg::AGE_W-1:0]    age_interval,
  input  logic                            out_free,
  output logic                            idle,
  output logic                            done,
  output ccache_pkg::res_t                res,
  output ccache_pkg::mem_req_t            mem_req,
  input  logic [ccache_pkg::KEY_BITS-1:0] rd_key
);
  import ccache_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SWEEP  = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0]          state_r,    state_nxt;
  logic [1:0]          func_r,     func_nxt;
  logic [KEY_BITS-1:0] key_r,      key_nxt;
  logic [CNT_W-1:0]    cnt_r,      cnt_nxt;
  logic                pend_r,     pend_nxt;
  logic [IDX_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic                hit_r,      hit_nxt;
  logic [IDX_W-1:0]    hit_idx_r,  hit_idx_nxt;
  logic                free_r,     free_nxt;
  logic [IDX_W-1:0]    free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0]    occ_r,      occ_nxt;
  logic [SLOTS-1:0]    valid_r,    valid_nxt;
  logic [SLOTS-1:0]    ref_r,      ref_nxt;
  logic [IDX_W-1:0]    hand_r,     hand_nxt;
  logic [AGE_W-1:0]    tick_r,     tick_nxt;
  res_t                res_r,      res_nxt;

  logic [AGE_W-1:0]    tick_inc;
  logic [IDX_W-1:0]    hand_adv;
  logic                key_eq;

  // shared comparator against the key read last cycle
  assign key_eq   = (rd_key == key_r);
  assign tick_inc = tick_r + AGE_W'(1);
  assign hand_adv = (({1'b0, hand_r} + CNT_W'(1)) == n_act) ? '0 : hand_r + IDX_W'(1);

  always_comb begin
    state_nxt    = state_r;
    func_nxt     = func_r;
    key_nxt      = key_r;
    cnt_nxt      = cnt_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    occ_nxt      = occ_r;
    valid_nxt    = valid_r;
    ref_nxt      = ref_r;
    hand_nxt     = hand_r;
    tick_nxt     = tick_r;
    res_nxt      = res_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = hand_r;
    mem_req.wdata = key_r;
    mem_req.raddr = cnt_r[IDX_W-1:0];
    done          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt  = func;
          key_nxt   = key;
          cnt_nxt   = '0;
          pend_nxt  = 1'b0;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          occ_nxt   = '0;
          state_nxt = S_SCAN;
          // aging counter advances on the accepting edge
          if (func == FUNC_TICK) begin
            if (tick_inc >= age_interval) begin
              ref_nxt  = ref_r & ~valid_r;
              tick_nxt = '0;
            end else begin
              tick_nxt = tick_inc;
            end
          end
        end
      end

      S_SCAN: begin
        // evaluate slot read in the previous cycle
        if (pend_r) begin
          if (valid_r[pend_idx_r]) begin
            occ_nxt = occ_r + CNT_W'(1);
            if (key_eq && !hit_r) begin
              hit_nxt     = 1'b1;
              hit_idx_nxt = pend_idx_r;
            end
          end else if (!free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = pend_idx_r;
          end
        end
        // issue next read
        if (cnt_r < n_act) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt      = cnt_r + CNT_W'(1);
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        res_nxt.hit        = 1'b0;
        res_nxt.value      = '0;
        res_nxt.slot_index = '0;
        res_nxt.occupancy  = occ_r;
        state_nxt          = S_FIN;
        if (func_r != FUNC_TICK) begin
          if (hit_r) begin
            res_nxt.hit        = 1'b1;
            res_nxt.slot_index = hit_idx_r;
            if (func_r != FUNC_EXISTS) begin
              ref_nxt[hit_idx_r] = 1'b1;
            end
            if (func_r == FUNC_FETCH) begin
              res_nxt.value = key_r;
            end
          end else if (func_r == FUNC_INSERT) begin
            if (free_r) begin
              mem_req.we            = 1'b1;
              mem_req.waddr         = free_idx_r;
              valid_nxt[free_idx_r] = 1'b1;
              ref_nxt[free_idx_r]   = 1'b1;
              res_nxt.slot_index    = free_idx_r;
              res_nxt.occupancy     = occ_r + CNT_W'(1);
            end else begin
              // hand outside the active range restarts at slot 0
              if ({1'b0, hand_r} >= n_act) begin
                hand_nxt = '0;
              end
              state_nxt = S_SWEEP;
            end
          end
        end
      end

      S_SWEEP: begin
        if (ref_r[hand_r]) begin
          // second chance
          ref_nxt[hand_r] = 1'b0;
          hand_nxt        = hand_adv;
        end else begin
          mem_req.we         = 1'b1;
          mem_req.waddr      = hand_r;
          valid_nxt[hand_r]  = 1'b1;
          ref_nxt[hand_r]    = 1'b1;
          res_nxt.slot_index = hand_r;
          hand_nxt           = hand_adv;
          state_nxt          = S_FIN;
        end
      end

      S_FIN: begin
        done = 1'b1;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      hit_r   <= 1'b0;
      free_r  <= 1'b0;
      cnt_r   <= '0;
      occ_r   <= '0;
      valid_r <= '0;
      ref_r   <= '0;
      hand_r  <= '0;
      tick_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      hit_r   <= hit_nxt;
      free_r  <= free_nxt;
      cnt_r   <= cnt_nxt;
      occ_r   <= occ_nxt;
      valid_r <= valid_nxt;
      ref_r   <= ref_nxt;
      hand_r  <= hand_nxt;
      tick_r  <= tick_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    key_r      <= key_nxt;
    pend_idx_r <= pend_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    res_r      <= res_nxt;
  end

  assign idle = (state_r == S_IDLE);
  assign res  = res_r;

  // the chosen fill slot was found empty
  a_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && free_r) |-> !valid_r[free_idx_r])
    else $error("fill slot already occupied");

  // a victim ends up valid and referenced
  a_victim_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && !ref_r[hand_r])
      |=> (valid_r[$past(hand_r)] && ref_r[$past(hand_r)]))
    else $error("victim slot not filled");

  // scan never counts more slots than are active
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |-> (occ_r <= n_act))
    else $error("occupancy above active slot count");

  // sweep only starts with every active slot occupied
  a_sweep_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE && $stable(state_r) == 1'b0 && func_r == FUNC_INSERT
      && !hit_r && !free_r) |=> (state_r == S_SWEEP && occ_r == n_act))
    else $error("victim sweep without a full cache");

endmodule

[sv/clock_replacement_cache_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_replacement_cache_top
// Fully associative key cache with CLOCK (second-chance) replacement.
// ----------------------------------------------------------------------------
// One word at a time: an accepted item is run through a one-slot-per-cycle
// scan of the key memory through a single comparator, which also counts the
// occupancy and finds the lowest free slot, and its result then goes to the
// output register. An insert that must evict adds the hand sweep after the
// scan. in_ready is high only between items; the output register lets the
// next word be taken while a result waits. Valid and reference bits reset
// to zero, so the key memory needs no clearing pass.
module clock_replacement_cache_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // input words
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_func,
  input  logic [ccache_pkg::KEY_BITS-1:0] in_key,
  // result words
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_hit,
  output logic [ccache_pkg::KEY_BITS-1:0] out_value,
  output logic [ccache_pkg::IDX_W-1:0]    out_slot_index,
  output logic [ccache_pkg::CNT_W-1:0]    out_occupancy,
  // configuration
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [ccache_pkg::AGE_W-1:0]    cfg_wdata
);
  import ccache_pkg::*;

  logic [CNT_W-1:0]    slots_r;
  logic [AGE_W-1:0]    age_r;
  logic [CNT_W-1:0]    n_act;
  logic                seq_idle;
  logic                seq_done;
  logic                out_free;
  logic                out_valid_r;
  res_t                seq_res;
  res_t                out_r;
  mem_req_t            mem_req;
  logic [KEY_BITS-1:0] rd_key;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= SLOTS_RESET;
      age_r   <= AGE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLOTS: slots_r <= cfg_wdata[CNT_W-1:0];
        REG_AGE:   age_r   <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  // active slot count: zero reads as one, saturate at SLOTS
  always_comb begin
    if (slots_r == '0) begin
      n_act = CNT_W'(1);
    end else if (slots_r > CNT_W'(SLOTS)) begin
      n_act = CNT_W'(SLOTS);
    end else begin
      n_act = slots_r;
    end
  end

  ccache_key_store u_store (
    .clk    (clk),
    .req    (mem_req),
    .rd_key (rd_key)
  );

  ccache_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_valid && seq_idle),
    .func         (in_func),
    .key          (in_key),
    .n_act        (n_act),
    .age_interval (age_r),
    .out_free     (out_free),
    .idle         (seq_idle),
    .done         (seq_done),
    .res          (seq_res),
    .mem_req      (mem_req),
    .rd_key       (rd_key)
  );

  // output register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= seq_done;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && seq_done) begin
      out_r <= seq_res;
    end
  end

  assign in_ready       = seq_idle;
  assign out_valid      = out_valid_r;
  assign out_hit        = out_r.hit;
  assign out_value      = out_r.value;
  assign out_slot_index = out_r.slot_index;
  assign out_occupancy  = out_r.occupancy;

endmodule

[tb/clock_replacement_cache_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_replacement_cache_top_tb
// Self-checking bench for the CLOCK replacement cache. A short directed table
// covers the empty cache, extreme keys, every operation, slot counts of zero
// and above the maximum, lowered slot counts and the aging corner cases.
// Randomized phases follow, each with its own slot count and aging interval.
// Every accepted word is run through a behavioral model of the cache; each
// result word is compared field by field with the model or a typed row's word.
// ----------------------------------------------------------------------------
module clock_replacement_cache_top_tb;
  import ccache_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int RX_HOLD_CYCLES  = 300;
  localparam int N_PHASES        = 14;
  localparam int WORDS_PER_PHASE = 125;
  localparam int POOL_MAX        = 26;
  localparam int SETTLE_CYCLES   = 40;
  localparam int MAX_REPORTS     = 10;

  typedef enum logic {ROW_OP, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [1:0]          func;
    logic [KEY_BITS-1:0] key;
    bit                  typed;
    res_t                exp;
    logic                reg_idx;
    logic [AGE_W-1:0]    reg_val;
  } stim_row_t;

  // DUT signals
  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_func;
  logic [KEY_BITS-1:0] in_key;
  logic                out_valid;
  logic                out_ready;
  logic                out_hit;
  logic [KEY_BITS-1:0] out_value;
  logic [IDX_W-1:0]    out_slot_index;
  logic [CNT_W-1:0]    out_occupancy;
  logic                cfg_we;
  logic                cfg_index;
  logic [AGE_W-1:0]    cfg_wdata;

  // cache model state
  logic [KEY_BITS-1:0] pk_keys [SLOTS];
  bit                  pk_valid [SLOTS];
  bit                  pk_ref [SLOTS];
  int                  pk_hand = 0;
  logic [AGE_W-1:0]    pk_ticks = '0;
  logic [4:0]          pk_slots = 5'(SLOTS_RESET);
  logic [AGE_W-1:0]    pk_age = AGE_RESET;

  // bookkeeping
  res_t                expected_words [$];
  bit                  cur_typed = 0;
  res_t                cur_exp = '0;
  bit                  no_idle = 0;
  bit                  hold_req = 0;
  int                  idle_cycles = 0;
  int                  failures = 0;
  int                  reports = 0;
  int                  words_checked = 0;
  int                  hits_seen = 0;
  int                  evictions = 0;
  int                  agings = 0;
  int                  reg_writes = 0;

  stim_row_t           dir_table [$];
  logic [KEY_BITS-1:0] key_pool [POOL_MAX];

  clock_replacement_cache_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_key        (in_key),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hit       (out_hit),
    .out_value     (out_value),
    .out_slot_index(out_slot_index),
    .out_occupancy (out_occupancy),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // slot count as the cache sees it: zero acts as one, large values saturate
  function automatic int eff_slots();
    if (pk_slots == 5'd0) return 1;
    if (int'(pk_slots) > SLOTS) return SLOTS;
    return int'(pk_slots);
  endfunction

  // next result of the cache for one word; updates the model state
  function automatic res_t cache_predict(logic [1:0] f, logic [KEY_BITS-1:0] k);
    res_t r;
    int   n;
    int   pos;
    int   tgt;
    r   = '0;
    n   = eff_slots();
    pos = -1;
    if (f == FUNC_TICK) begin
      pk_ticks = pk_ticks + 1'b1;
      if (pk_ticks >= pk_age) begin
        // aging also clears bits of slots above the active count
        for (int i = 0; i < SLOTS; i++) if (pk_valid[i]) pk_ref[i] = 1'b0;
        pk_ticks = '0;
        agings++;
      end
    end else begin
      for (int i = 0; i < n; i++)
        if (pos < 0 && pk_valid[i] && pk_keys[i] == k) pos = i;
      if (pos >= 0) begin
        r.hit        = 1'b1;
        r.slot_index = IDX_W'(pos);
        if (f != FUNC_EXISTS) pk_ref[pos] = 1'b1;
        if (f == FUNC_FETCH) r.value = pk_keys[pos];
        hits_seen++;
      end else if (f == FUNC_INSERT) begin
        tgt = n;
        for (int i = n - 1; i >= 0; i--) if (!pk_valid[i]) tgt = i;
        if (tgt == n) begin
          // second-chance sweep; a hand left outside the active slots wraps
          if (pk_hand >= n) pk_hand = 0;
          while (pk_ref[pk_hand]) begin
            pk_ref[pk_hand] = 1'b0;
            pk_hand = (pk_hand + 1) % n;
          end
          tgt = pk_hand;
          pk_hand = (tgt + 1) % n;
          evictions++;
        end
        pk_keys[tgt]  = k;
        pk_valid[tgt] = 1'b1;
        pk_ref[tgt]   = 1'b1;
        r.slot_index  = IDX_W'(tgt);
      end
    end
    for (int i = 0; i < n; i++) if (pk_valid[i]) r.occupancy = r.occupancy + 1'b1;
    return r;
  endfunction

  // gap lengths: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic stim_row_t row_op(logic [1:0] f, logic [KEY_BITS-1:0] k);
    stim_row_t r;
    r = '{kind: ROW_OP, func: f, key: k, typed: 0, exp: '0, reg_idx: REG_SLOTS,
          reg_val: '0};
    return r;
  endfunction

  function automatic stim_row_t row_op_exp(logic [1:0] f, logic [KEY_BITS-1:0] k,
                                           logic h, logic [KEY_BITS-1:0] v,
                                           int s, int o);
    stim_row_t r;
    r = row_op(f, k);
    r.typed = 1;
    r.exp   = '{hit: h, value: v, slot_index: IDX_W'(s), occupancy: CNT_W'(o)};
    return r;
  endfunction

  function automatic stim_row_t row_reg(logic idx, logic [AGE_W-1:0] val);
    stim_row_t r;
    r = row_op(FUNC_TICK, '0);
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // offer one word and return at the falling edge after it is taken
  task automatic send_word(logic [1:0] f, logic [KEY_BITS-1:0] k, bit typed,
                           res_t exp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func   = f;
    in_key    = k;
    cur_typed = typed;
    cur_exp   = exp;
    in_valid  = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // hold the input until every outstanding result has come back
  task automatic drain_results();
    in_valid = 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [AGE_W-1:0] val);
    drain_results();
    cfg_index = idx;
    cfg_wdata = val;
    cfg_we    = 1'b1;
    if (idx == REG_SLOTS) pk_slots = val[4:0];
    else pk_age = val;
    reg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // result checker; also feeds each accepted word to the model
  always @(posedge clk) begin : check_p
    res_t want;
    res_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want = cache_predict(in_func, in_key);
        if (cur_typed) want = cur_exp;
        expected_words.push_back(want);
      end
      if (out_valid && out_ready) begin
        got.hit        = out_hit;
        got.value      = out_value;
        got.slot_index = out_slot_index;
        got.occupancy  = out_occupancy;
        if (expected_words.size() == 0) begin
          failures++;
          if (reports < MAX_REPORTS)
            $display("%0t: unexpected result word hit=%0b value=%h slot=%0d occ=%0d",
                     $realtime, got.hit, got.value, got.slot_index, got.occupancy);
          reports++;
        end else begin
          want = expected_words.pop_front();
          if (got.hit !== want.hit || got.value !== want.value ||
              got.slot_index !== want.slot_index || got.occupancy !== want.occupancy) begin
            failures++;
            if (reports < MAX_REPORTS)
              $display("%0t: word %0d exp hit=%0b value=%h slot=%0d occ=%0d, got %0b %h %0d %0d",
                       $realtime, words_checked, want.hit, want.value, want.slot_index,
                       want.occupancy, got.hit, got.value, got.slot_index, got.occupancy);
            reports++;
          end
          words_checked++;
        end
      end
    end
  end

  // watchdog: cycles without a handshake on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d idle cycles", idle_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : sink_p
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready  = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // stimulus
  initial begin : stim_p
    int                  slot_set [N_PHASES];
    int                  age_set [N_PHASES];
    int                  n;
    int                  psize;
    int                  r;
    logic [1:0]          f;
    logic [KEY_BITS-1:0] k;
    stim_row_t           row;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_func   = FUNC_INSERT;
    in_key    = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_SLOTS;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty cache, extreme keys, then the slot and aging corners
    dir_table.push_back(row_op_exp(FUNC_FETCH,  32'h0000_0000, 0, 32'h0, 0, 0));
    dir_table.push_back(row_op_exp(FUNC_EXISTS, 32'hFFFF_FFFF, 0, 32'h0, 0, 0));
    dir_table.push_back(row_op_exp(FUNC_TICK,   32'h1234_5678, 0, 32'h0, 0, 0));
    dir_table.push_back(row_op_exp(FUNC_INSERT, 32'h0000_0000, 0, 32'h0, 0, 1));
    dir_table.push_back(row_op_exp(FUNC_INSERT, 32'hFFFF_FFFF, 0, 32'h0, 1, 2));
    dir_table.push_back(row_op_exp(FUNC_FETCH,  32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 2));
    dir_table.push_back(row_op_exp(FUNC_EXISTS, 32'h0000_0000, 1, 32'h0, 0, 2));
    dir_table.push_back(row_op_exp(FUNC_INSERT, 32'h0000_0000, 1, 32'h0, 0, 2));
    dir_table.push_back(row_op_exp(FUNC_FETCH,  32'h0000_0000, 1, 32'h0, 0, 2));
    dir_table.push_back(row_reg(REG_SLOTS, 16'd0));       // zero acts as one slot
    dir_table.push_back(row_op(FUNC_INSERT, 32'h0000_0005));
    dir_table.push_back(row_op(FUNC_FETCH,  32'hFFFF_FFFF)); // beyond active slots
    dir_table.push_back(row_reg(REG_AGE, 16'd0));         // age on every tick
    dir_table.push_back(row_op(FUNC_TICK,   32'hAAAA_5555));
    dir_table.push_back(row_reg(REG_SLOTS, 16'd31));      // saturates
    dir_table.push_back(row_op(FUNC_FETCH,  32'hFFFF_FFFF)); // old contents back
    dir_table.push_back(row_op(FUNC_EXISTS, 32'h0000_0005));
    dir_table.push_back(row_reg(REG_SLOTS, 16'd2));       // hand may sit outside
    dir_table.push_back(row_op(FUNC_INSERT, 32'h0000_0007));
    dir_table.push_back(row_op(FUNC_INSERT, 32'h0000_0008));
    dir_table.push_back(row_op(FUNC_INSERT, 32'h0000_0007));
    dir_table.push_back(row_op(FUNC_INSERT, 32'h0000_0009));
    dir_table.push_back(row_reg(REG_AGE, 16'hFFFF));
    dir_table.push_back(row_op(FUNC_TICK,   32'h5555_AAAA));
    dir_table.push_back(row_op(FUNC_TICK,   32'h0000_0000));
    dir_table.push_back(row_reg(REG_AGE, 16'd1));         // interval below count
    dir_table.push_back(row_op(FUNC_TICK,   32'hFFFF_FFFF));
    dir_table.push_back(row_op(FUNC_INSERT, 32'h8000_0001));
    dir_table.push_back(row_op(FUNC_FETCH,  32'h0000_0008));

    foreach (dir_table[i]) begin
      row = dir_table[i];
      if (row.kind == ROW_REG) write_reg(row.reg_idx, row.reg_val);
      else send_word(row.func, row.key, row.typed, row.exp);
    end

    // random phases, each with its own register setting
    slot_set = '{16, 1, 2, 4, 31, 3, 8, 0, 15, 17, 16, 5, 2, 16};
    age_set  = '{500, 1, 3, 0, 65535, 7, 2, 20, 1, 40, 5, 0, 10, 65535};
    slot_set[N_PHASES-1] = $urandom_range(0, 31);
    age_set[N_PHASES-1]  = $urandom_range(0, 65535);

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(REG_SLOTS, AGE_W'(slot_set[p]));
      write_reg(REG_AGE, AGE_W'(age_set[p]));
      n     = eff_slots();
      psize = n + n / 2 + 2;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int j = 2; j < POOL_MAX; j++) key_pool[j] = $urandom;
      no_idle = (p % 4 == 3);
      // first phase: long hold-off on the result side while words keep coming
      if (p == 0) hold_req = 1;
      for (int j = 0; j < WORDS_PER_PHASE; j++) begin
        r = $urandom_range(0, 99);
        if (r < 40) f = FUNC_INSERT;
        else if (r < 65) f = FUNC_FETCH;
        else if (r < 85) f = FUNC_EXISTS;
        else f = FUNC_TICK;
        if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, psize - 1)];
        else k = $urandom;
        send_word(f, k, 0, '0);
        // occasional full stop on the input side
        if ($urandom_range(0, 199) == 0) drain_results();
      end
      no_idle = 0;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_words.size() != 0) begin
      failures++;
      $display("%0d result words never arrived", expected_words.size());
    end

    $display("Checked %0d words over %0d register writes, slot counts 0..31, intervals 0..65535.",
             words_checked, reg_writes);
    $display("Model saw %0d hits, %0d evictions and %0d agings; %0d failures.",
             hits_seen, evictions, agings, failures);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
